/* sv/aest_pkg.sv */
// Shared types and constants for the adaptive event send trigger.
package aest_pkg;

    localparam int NORM_W = 32;
    localparam int PASS_W = 24;
    localparam int SLOT_IN_W = 6;
    localparam int FACTOR_W = 24;
    localparam int WARM_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_PASSES = 3'd3;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd65536;
    localparam logic [WARM_W-1:0] WARMUP_RESET = 16'd30;
    localparam logic [NORM_W-1:0] NORM_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_index;
        logic [NORM_W-1:0]    current_norm;
        logic [PASS_W-1:0]    pass_number;
    } t_in_item;

    typedef struct packed {
        logic              send_event;
        logic [NORM_W-1:0] threshold_used;
        logic [NORM_W-1:0] norm_change;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV_SLOPE,
        ST_SHIFT,
        ST_SUM,
        ST_DIV_MEAN,
        ST_UPDATE,
        ST_WRITE
    } t_state;

endpackage

/* sv/adaptive_event_send_trigger_core.sv */
// Adaptive event send trigger: per-slot state in one memory, serial divider, result strobe.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  item in  | start, busy             | i_item (slot_index, current_norm, pass_number)
//  result   | o_valid (one cycle)     | o_result (send_event, threshold_used, norm_change)
//  config   | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item without a send goes from start through the read and evaluate states to the
// result strobe. An item with a send adds the slope division (one quotient bit per cycle),
// a shift step, a sum over the HISTORY_LEN history entries, an update step, and a second
// division when HISTORY_LEN is not a power of two.
// After reset the memory is cleared one slot per cycle, with busy high until all SLOT_COUNT slots are cleared.
// The result is shown for one cycle only; the receiver cannot stall it.
module adaptive_event_send_trigger_core #(
    parameter int SLOT_COUNT = 64,
    parameter int HISTORY_LEN = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  aest_pkg::t_in_item                i_item,
    output logic                              o_valid,
    output aest_pkg::t_out_item               o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aest_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aest_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_IN_N = 2 ** aest_pkg::SLOT_IN_W;
    localparam int HIST_LOG = $clog2(HISTORY_LEN);
    localparam bit HIST_POW2 = ((HISTORY_LEN & (HISTORY_LEN - 1)) == 0);
    localparam int SUM_W = aest_pkg::NORM_W + HIST_LOG;
    localparam int CNT_W = $clog2(SUM_W);
    localparam int PROD_W = aest_pkg::NORM_W + aest_pkg::FACTOR_W;
    localparam int NW = aest_pkg::NORM_W;
    localparam int PW = aest_pkg::PASS_W;

    typedef struct packed {
        logic [HISTORY_LEN-1:0][NW-1:0] hist;
        logic [PW-1:0]                  pass;
        logic [NW-1:0]                  norm;
        logic [NW-1:0]                  thr;
    } t_row;

    t_row r_mem [SLOT_COUNT];
    t_row r_rd;
    t_row r_row;

    aest_pkg::t_state r_state;
    aest_pkg::t_state n_state;

    logic                       r_mode;
    logic [aest_pkg::FACTOR_W-1:0] r_factor;
    logic [NW-1:0]              r_const;
    logic [aest_pkg::WARM_W-1:0] r_warm;

    logic [SLOT_BITS-1:0] r_slot;
    logic [SLOT_BITS-1:0] r_clr_addr;
    logic [NW-1:0]        r_norm;
    logic [PW-1:0]        r_pass;
    logic [PROD_W-1:0]    r_prod;
    logic [NW-1:0]        r_thr;
    logic [NW-1:0]        r_change;
    logic                 r_fire;
    logic [SUM_W-1:0]     r_quo;
    logic [PW-1:0]        r_rem;
    logic [PW-1:0]        r_dvs;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;

    logic [SLOT_BITS-1:0] w_slot_map [SLOT_IN_N];
    logic [SLOT_BITS-1:0] w_slot;
    logic                 w_accept;
    logic [NW-1:0]        w_thr;
    logic [NW-1:0]        w_change;
    logic                 w_fire;
    logic [PW:0]          w_rem_sh;
    logic                 w_ge;
    logic [PW:0]          w_diff;
    logic                 w_div_last;
    logic                 w_sum_last;
    logic [SUM_W-1:0]     w_sum_next;
    logic [SUM_W-1:0]     w_mean_shift;
    logic [NW-1:0]        w_mean;

    for (genvar g = 0; g < SLOT_IN_N; g++) begin : g_slot_map
        assign w_slot_map[g] = SLOT_BITS'(g % SLOT_COUNT);
    end

    assign w_slot = w_slot_map[i_item.slot_index];
    assign busy = (r_state != aest_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign w_thr = !r_mode ? r_const :
                   (|r_prod[PROD_W-1:NW+16]) ? aest_pkg::NORM_MAX : r_prod[NW+15:16];
    assign w_change = (r_norm >= r_row.norm) ? (r_norm - r_row.norm) : (r_row.norm - r_norm);
    assign w_fire = (w_change >= w_thr) || (r_pass < PW'(r_warm));

    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_ge = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff = w_rem_sh - {1'b0, r_dvs};
    assign w_div_last = (r_cnt == CNT_W'(SUM_W - 1));
    assign w_sum_last = (r_cnt == CNT_W'(HISTORY_LEN - 1));
    assign w_sum_next = r_sum + SUM_W'(r_row.hist[0]);
    assign w_mean_shift = r_sum >> HIST_LOG;
    assign w_mean = HIST_POW2 ? w_mean_shift[NW-1:0] : r_quo[NW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aest_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_valid = 1'b0;
        case (r_state)
            aest_pkg::ST_CLEAR: begin
                if (r_clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = aest_pkg::ST_IDLE;
                end
            end
            aest_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = aest_pkg::ST_READ;
                end
            end
            aest_pkg::ST_READ: n_state = aest_pkg::ST_EVAL;
            aest_pkg::ST_EVAL: begin
                n_state = w_fire ? aest_pkg::ST_DIV_SLOPE : aest_pkg::ST_WRITE;
            end
            aest_pkg::ST_DIV_SLOPE: begin
                if (w_div_last) begin
                    n_state = aest_pkg::ST_SHIFT;
                end
            end
            aest_pkg::ST_SHIFT: n_state = aest_pkg::ST_SUM;
            aest_pkg::ST_SUM: begin
                if (w_sum_last) begin
                    n_state = HIST_POW2 ? aest_pkg::ST_UPDATE : aest_pkg::ST_DIV_MEAN;
                end
            end
            aest_pkg::ST_DIV_MEAN: begin
                if (w_div_last) begin
                    n_state = aest_pkg::ST_UPDATE;
                end
            end
            aest_pkg::ST_UPDATE: n_state = aest_pkg::ST_WRITE;
            aest_pkg::ST_WRITE: begin
                o_valid = 1'b1;
                n_state = aest_pkg::ST_IDLE;
            end
            default: n_state = aest_pkg::ST_IDLE;
        endcase
    end

    assign o_result.send_event = r_fire;
    assign o_result.threshold_used = r_thr;
    assign o_result.norm_change = r_change;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_factor <= aest_pkg::FACTOR_RESET;
            r_const <= '0;
            r_warm <= aest_pkg::WARMUP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aest_pkg::CFG_ADAPTIVE_MODE: r_mode <= i_cfg_data[0];
                aest_pkg::CFG_HORIZON_FACTOR: r_factor <= i_cfg_data[aest_pkg::FACTOR_W-1:0];
                aest_pkg::CFG_CONSTANT_THRESHOLD: r_const <= i_cfg_data[NW-1:0];
                aest_pkg::CFG_WARMUP_PASSES: r_warm <= i_cfg_data[aest_pkg::WARM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == aest_pkg::ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + SLOT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aest_pkg::ST_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_state == aest_pkg::ST_WRITE) begin
            r_mem[r_slot] <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            aest_pkg::ST_IDLE: begin
                r_slot <= w_slot;
                r_norm <= i_item.current_norm;
                r_pass <= i_item.pass_number;
            end
            aest_pkg::ST_READ: begin
                r_row <= r_rd;
                r_prod <= PROD_W'(r_rd.thr) * PROD_W'(r_factor);
            end
            aest_pkg::ST_EVAL: begin
                r_thr <= w_thr;
                r_change <= w_change;
                r_fire <= w_fire;
                r_row.thr <= w_thr;
                r_quo <= SUM_W'(w_change);
                r_rem <= '0;
                r_cnt <= '0;
                r_dvs <= (r_pass > r_row.pass) ? (r_pass - r_row.pass) : '0;
            end
            aest_pkg::ST_DIV_SLOPE, aest_pkg::ST_DIV_MEAN: begin
                r_rem <= w_ge ? w_diff[PW-1:0] : w_rem_sh[PW-1:0];
                r_quo <= {r_quo[SUM_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            aest_pkg::ST_SHIFT: begin
                for (int j = 0; j < HISTORY_LEN - 1; j++) begin
                    r_row.hist[j] <= r_row.hist[j+1];
                end
                r_row.hist[HISTORY_LEN-1] <= r_quo[NW-1:0];
                r_row.norm <= r_norm;
                r_row.pass <= r_pass;
                r_sum <= '0;
                r_cnt <= '0;
                r_dvs <= PW'(HISTORY_LEN);
            end
            aest_pkg::ST_SUM: begin
                for (int j = 0; j < HISTORY_LEN - 1; j++) begin
                    r_row.hist[j] <= r_row.hist[j+1];
                end
                r_row.hist[HISTORY_LEN-1] <= r_row.hist[0];
                r_sum <= w_sum_next;
                r_quo <= w_sum_next;
                r_rem <= '0;
                r_cnt <= w_sum_last ? '0 : (r_cnt + CNT_W'(1));
            end
            aest_pkg::ST_UPDATE: begin
                if (r_mode) begin
                    r_row.thr <= w_mean;
                end
            end
            default: ;
        endcase
    end

endmodule
